FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/sasc_pkg.sv
`timescale 1ns / 1ps

package sasc_pkg;

    typedef logic [15:0] t_word;
    typedef logic [7:0]  t_alpha;
    typedef logic [9:0]  t_coord;
    typedef logic [14:0] t_load_index;
    typedef logic [8:0]  t_scale;
    typedef logic [0:0]  t_cfg_index;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam t_cfg_index CFG_SCALE      = 1'b0;
    localparam t_cfg_index CFG_BACKGROUND = 1'b1;

    localparam t_scale SCALE_RESET = 9'd100;
    localparam t_word  BG_RESET    = 16'h0000;

    // Exact floor(n / 25) for n below 2**18.
    localparam logic [18:0] DIV25_MUL   = 19'd335545;
    localparam int          DIV25_SHIFT = 23;

    typedef struct packed {
        logic        is_render;
        logic        oor;
        t_load_index load_index;
        t_word       pixel_word;
        t_alpha      alpha;
    } t_item;

    typedef struct packed {
        t_word color;
        logic  oor;
    } t_result;

    typedef logic [7:0] t_exp5_tab [32];
    typedef logic [7:0] t_exp6_tab [64];

    function automatic t_exp5_tab f_exp5_tab();
        t_exp5_tab tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * 255) / 31);
        end
        return tab;
    endfunction

    function automatic t_exp6_tab f_exp6_tab();
        t_exp6_tab tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((i * 255) / 63);
        end
        return tab;
    endfunction

    localparam t_exp5_tab EXP5_TAB = f_exp5_tab();
    localparam t_exp6_tab EXP6_TAB = f_exp6_tab();

endpackage

FILE: rtl/sasc_ram.sv
`timescale 1ns / 1ps

module sasc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sasc_div.sv
`timescale 1ns / 1ps

module sasc_div #(
    parameter int NW = 20,
    parameter int DW = 14,
    parameter int QW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sasc_pkg::t_item i_item,
    input  logic [NW-1:0]   i_num_x,
    input  logic [NW-1:0]   i_num_y,
    input  logic [DW-1:0]   i_den_x,
    input  logic [DW-1:0]   i_den_y,
    output logic            o_valid,
    output sasc_pkg::t_item o_item,
    output logic [QW-1:0]   o_qx,
    output logic [QW-1:0]   o_qy
);

    import sasc_pkg::*;

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_valid [QW];
    t_item         r_item  [QW];
    logic [NW-1:0] r_rem_x [QW];
    logic [NW-1:0] r_rem_y [QW];
    logic [QW-1:0] r_q_x   [QW];
    logic [QW-1:0] r_q_y   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;

        logic          w_valid_in;
        t_item         w_item_in;
        logic [NW-1:0] w_rem_x_in;
        logic [NW-1:0] w_rem_y_in;
        logic [QW-1:0] w_q_x_in;
        logic [QW-1:0] w_q_y_in;
        logic [CW-1:0] w_trial_x;
        logic [CW-1:0] w_trial_y;
        logic [NW-1:0] n_rem_x;
        logic [NW-1:0] n_rem_y;
        logic [QW-1:0] n_q_x;
        logic [QW-1:0] n_q_y;

        if (k == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_item_in  = i_item;
            assign w_rem_x_in = i_num_x;
            assign w_rem_y_in = i_num_y;
            assign w_q_x_in   = '0;
            assign w_q_y_in   = '0;
        end else begin : g_next
            assign w_valid_in = r_valid[k-1];
            assign w_item_in  = r_item[k-1];
            assign w_rem_x_in = r_rem_x[k-1];
            assign w_rem_y_in = r_rem_y[k-1];
            assign w_q_x_in   = r_q_x[k-1];
            assign w_q_y_in   = r_q_y[k-1];
        end

        assign w_trial_x = CW'(i_den_x) << SH;
        assign w_trial_y = CW'(i_den_y) << SH;

        always_comb begin
            n_rem_x = w_rem_x_in;
            n_q_x   = w_q_x_in;
            if (CW'(w_rem_x_in) >= w_trial_x) begin
                n_rem_x   = NW'(CW'(w_rem_x_in) - w_trial_x);
                n_q_x[SH] = 1'b1;
            end
            n_rem_y = w_rem_y_in;
            n_q_y   = w_q_y_in;
            if (CW'(w_rem_y_in) >= w_trial_y) begin
                n_rem_y   = NW'(CW'(w_rem_y_in) - w_trial_y);
                n_q_y[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k]  <= w_item_in;
                r_rem_x[k] <= n_rem_x;
                r_rem_y[k] <= n_rem_y;
                r_q_x[k]   <= n_q_x;
                r_q_y[k]   <= n_q_y;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_item  = r_item[QW-1];
    assign o_qx    = r_q_x[QW-1];
    assign o_qy    = r_q_y[QW-1];

endmodule

FILE: rtl/scaled_alpha_sprite_compositor_unit.sv
`timescale 1ns / 1ps

// Scaled alpha sprite compositor.
// Input channel (i_in_valid / o_in_stall): a load beat (i_cmd = 0) writes one
// sprite entry if its index is below DEPTH, a render beat (i_cmd = 1) asks
// for one output pixel. Output channel (o_out_valid / i_out_stall): one beat
// per render, none per load, in input order. Configuration is written over
// i_cfg_valid / o_cfg_ready, which is always ready; the user must write it
// only while no beat is in flight, which the block itself does not enforce.
// One beat is taken per cycle while o_in_stall is low. The coordinate divider
// has QW = clog2(max(SOURCE_WIDTH, SOURCE_HEIGHT)) stages for each render.
// Loads and renders meet the sprite memory at the same stage, so a render always
// sees every load taken before it.
// Reset clears all valid flags and loads scale 100 and a black background. The
// sprite memory is not cleared; an entry must be loaded before it is rendered.
// When the receiver stalls, the output register holds its beat and one more
// result goes into a skid register; o_in_stall then rises and the whole pipeline
// holds until the receiver takes the waiting beat.
module scaled_alpha_sprite_compositor_unit #(
    parameter int SOURCE_WIDTH  = 188,
    parameter int SOURCE_HEIGHT = 164
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  sasc_pkg::t_load_index i_load_index,
    input  sasc_pkg::t_word       i_pixel_word,
    input  sasc_pkg::t_alpha      i_alpha,
    input  sasc_pkg::t_coord      i_out_x,
    input  sasc_pkg::t_coord      i_out_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sasc_pkg::t_word       o_color,
    output logic                  o_out_of_range,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  sasc_pkg::t_cfg_index  i_cfg_index,
    input  sasc_pkg::t_word       i_cfg_data
);

    import sasc_pkg::*;

    localparam int DEPTH = SOURCE_WIDTH * SOURCE_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAXS  = (SOURCE_WIDTH > SOURCE_HEIGHT) ? SOURCE_WIDTH : SOURCE_HEIGHT;
    localparam int QW    = (MAXS > 1) ? $clog2(MAXS) : 1;
    localparam int NW    = $clog2(1023 * MAXS + 1);
    localparam int WDW   = $clog2((SOURCE_WIDTH * 511 + 99) / 100 + 1);
    localparam int HDW   = $clog2((SOURCE_HEIGHT * 511 + 99) / 100 + 1);
    localparam int DW    = (WDW > HDW) ? WDW : HDW;

    function automatic logic [15:0] f_blend(input logic [7:0] f, input logic [7:0] b,
                                            input logic [7:0] a);
        return 16'(16'(f) * 16'(a) + 16'(b) * 16'(8'd255 - a) + 16'd127);
    endfunction

    function automatic logic [7:0] f_div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    t_scale         r_scale;
    t_word          r_background;
    logic [17:0]    r_wnum;
    logic [17:0]    r_hnum;
    logic [WDW-1:0] r_width;
    logic [HDW-1:0] r_height;
    logic [19:0]    w_wprod;
    logic [19:0]    w_hprod;
    logic [36:0]    w_wq;
    logic [36:0]    w_hq;

    logic           w_adv;
    logic           w_in_acc;

    logic           r_s1_valid;
    logic           r_s1_cmd;
    t_load_index    r_s1_li;
    t_word          r_s1_pw;
    t_alpha         r_s1_alpha;
    t_coord         r_s1_x;
    t_coord         r_s1_y;

    logic           r_s2_valid;
    logic           r_s2_cmd;
    t_load_index    r_s2_li;
    t_word          r_s2_pw;
    t_alpha         r_s2_alpha;
    t_coord         r_s2_x;
    t_coord         r_s2_y;
    logic [NW-1:0]  r_s2_nx;
    logic [NW-1:0]  r_s2_ny;
    logic           w_s2_oor;
    t_item          w_s2_item;

    logic           w_div_valid;
    t_item          w_div_item;
    logic [QW-1:0]  w_qx;
    logic [QW-1:0]  w_qy;

    logic           r_s3_valid;
    t_item          r_s3_item;
    logic [AW-1:0]  r_s3_idx;
    logic           w_load_ok;
    logic           w_we;
    logic           w_re;
    logic [23:0]    w_entry;

    logic           r_s4_valid;
    logic           r_s4_oor;
    t_word          w_src;
    t_word          w_bgn;
    t_alpha         w_a;

    logic           r_s5_valid;
    logic           r_s5_oor;
    logic           r_s5_azero;
    logic [15:0]    r_s5_sum_r;
    logic [15:0]    r_s5_sum_g;
    logic [15:0]    r_s5_sum_b;
    logic [7:0]     w_r8;
    logic [7:0]     w_g8;
    logic [7:0]     w_b8;
    t_word          w_native;
    t_result        w_result;

    logic           r_out_valid;
    t_result        r_out;
    logic           r_skid_valid;
    t_result        r_skid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RESET;
            r_background <= BG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALE:      r_scale      <= i_cfg_data[8:0];
                CFG_BACKGROUND: r_background <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Scaled size, ceil(size * scale / 100): r_wnum / r_hnum, then r_width / r_height.
    assign w_wprod = 20'(SOURCE_WIDTH) * 20'(r_scale) + 20'd99;
    assign w_hprod = 20'(SOURCE_HEIGHT) * 20'(r_scale) + 20'd99;
    assign w_wq    = 37'(r_wnum) * 37'(DIV25_MUL);
    assign w_hq    = 37'(r_hnum) * 37'(DIV25_MUL);

    always_ff @(posedge i_clk) begin
        r_wnum   <= w_wprod[19:2];
        r_hnum   <= w_hprod[19:2];
        r_width  <= WDW'(w_wq >> DIV25_SHIFT);
        r_height <= HDW'(w_hq >> DIV25_SHIFT);
    end

    assign w_adv      = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign w_in_acc   = i_in_valid && !r_skid_valid;

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cmd   <= i_cmd;
            r_s1_li    <= i_load_index;
            r_s1_pw    <= i_pixel_word;
            r_s1_alpha <= i_alpha;
            r_s1_x     <= i_out_x;
            r_s1_y     <= i_out_y;
        end
    end

    // Stage 2: dividends of the nearest-neighbor index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_li    <= r_s1_li;
            r_s2_pw    <= r_s1_pw;
            r_s2_alpha <= r_s1_alpha;
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            r_s2_nx    <= NW'(NW'(r_s1_x) * NW'(SOURCE_WIDTH));
            r_s2_ny    <= NW'(NW'(r_s1_y) * NW'(SOURCE_HEIGHT));
        end
    end

    assign w_s2_oor = (32'(r_s2_x) >= 32'(r_width)) || (32'(r_s2_y) >= 32'(r_height));

    always_comb begin
        w_s2_item.is_render  = (r_s2_cmd == CMD_RENDER);
        w_s2_item.oor        = w_s2_oor;
        w_s2_item.load_index = r_s2_li;
        w_s2_item.pixel_word = r_s2_pw;
        w_s2_item.alpha      = r_s2_alpha;
    end

    sasc_div #(
        .NW (NW),
        .DW (DW),
        .QW (QW)
    ) u_sasc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s2_valid),
        .i_item  (w_s2_item),
        .i_num_x (r_s2_nx),
        .i_num_y (r_s2_ny),
        .i_den_x (DW'(r_width)),
        .i_den_y (DW'(r_height)),
        .o_valid (w_div_valid),
        .o_item  (w_div_item),
        .o_qx    (w_qx),
        .o_qy    (w_qy)
    );

    // Stage 3: row-major address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_item <= w_div_item;
            r_s3_idx  <= AW'(int'(w_qy) * SOURCE_WIDTH + int'(w_qx));
        end
    end

    // Stage 4: sprite memory, written by loads and read by renders.
    assign w_load_ok = int'(r_s3_item.load_index) < DEPTH;
    assign w_we      = w_adv && r_s3_valid && !r_s3_item.is_render && w_load_ok;
    assign w_re      = w_adv && r_s3_valid && r_s3_item.is_render && !r_s3_item.oor;

    sasc_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_sasc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_s3_item.load_index)),
        .i_wdata ({r_s3_item.alpha, r_s3_item.pixel_word}),
        .i_re    (w_re),
        .i_raddr (r_s3_idx),
        .o_rdata (w_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s4_valid <= r_s3_valid && r_s3_item.is_render;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_oor <= r_s3_item.oor;
        end
    end

    // Stage 5: channel expansion and weighted sums.
    assign w_src = {w_entry[7:0], w_entry[15:8]};
    assign w_bgn = {r_background[7:0], r_background[15:8]};
    assign w_a   = w_entry[23:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_adv) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_oor   <= r_s4_oor;
            r_s5_azero <= (w_a == 8'd0);
            r_s5_sum_r <= f_blend(EXP5_TAB[w_src[15:11]], EXP5_TAB[w_bgn[15:11]], w_a);
            r_s5_sum_g <= f_blend(EXP6_TAB[w_src[10:5]], EXP6_TAB[w_bgn[10:5]], w_a);
            r_s5_sum_b <= f_blend(EXP5_TAB[w_src[4:0]], EXP5_TAB[w_bgn[4:0]], w_a);
        end
    end

    assign w_r8     = f_div255(r_s5_sum_r);
    assign w_g8     = f_div255(r_s5_sum_g);
    assign w_b8     = f_div255(r_s5_sum_b);
    assign w_native = {w_r8[7:3], w_g8[7:2], w_b8[7:3]};

    always_comb begin
        w_result.oor   = r_s5_oor;
        w_result.color = {w_native[7:0], w_native[15:8]};
        if (r_s5_oor || r_s5_azero) begin
            w_result.color = r_background;
        end
    end

    // Output register with one skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (r_s5_valid) begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end else if (!i_out_stall) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (r_s5_valid) begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out <= w_result;
                end else begin
                    r_skid <= w_result;
                end
            end
        end else if (!i_out_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_color        = r_out.color;
    assign o_out_of_range = r_out.oor;

endmodule

FILE: rtl/sasc_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sasc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input sasc_pkg::t_word o_color,
    input logic            o_out_of_range
);

    `ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset left a beat pending")

    `ASSERT_CLK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_color) && $stable(o_out_of_range), "stalled output beat changed")

    `ASSERT_CLK(a_stall_cause, $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall), "input stalled without a blocked output")

    `ASSERT_CLK(a_stall_full, o_in_stall |-> o_out_valid, "input stalled while output register empty")

endmodule

bind scaled_alpha_sprite_compositor_unit sasc_checker u_sasc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_color        (o_color),
    .o_out_of_range (o_out_of_range)
);

FILE: tb/scaled_alpha_sprite_compositor_unit_test.sv
`timescale 1ns / 1ps

module scaled_alpha_sprite_compositor_unit_test;

    import sasc_pkg::*;

    localparam int unsigned SRC_W        = 188;
    localparam int unsigned SRC_H        = 164;
    localparam int unsigned STORE_DEPTH  = SRC_W * SRC_H;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    t_load_index i_load_index;
    t_word       i_pixel_word;
    t_alpha      i_alpha;
    t_coord      i_out_x;
    t_coord      i_out_y;
    logic        o_out_valid;
    logic        i_out_stall;
    t_word       o_color;
    logic        o_out_of_range;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    t_word       i_cfg_data;

    logic [23:0] sprite_mem [STORE_DEPTH];
    bit          sprite_loaded [STORE_DEPTH];
    t_scale      scale_reg;
    t_word       bg_reg;
    t_result     results_due [$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned stall_left;
    int unsigned items_sent;
    bit          in_gaps_on;
    bit          out_gaps_on;

    scaled_alpha_sprite_compositor_unit #(
        .SOURCE_WIDTH (SRC_W),
        .SOURCE_HEIGHT(SRC_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_load_index  (i_load_index),
        .i_pixel_word  (i_pixel_word),
        .i_alpha       (i_alpha),
        .i_out_x       (i_out_x),
        .i_out_y       (i_out_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_color       (o_color),
        .o_out_of_range(o_out_of_range),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_word swap_bytes(t_word w);
        return {w[7:0], w[15:8]};
    endfunction

    function automatic int unsigned scaled_dim(int unsigned src);
        return (src * scale_reg + 99) / 100;
    endfunction

    function automatic bit coord_in_range(t_coord x, t_coord y);
        return (32'(x) < scaled_dim(SRC_W)) && (32'(y) < scaled_dim(SRC_H));
    endfunction

    function automatic int unsigned nearest_entry(t_coord x, t_coord y);
        int unsigned w;
        int unsigned h;
        w = scaled_dim(SRC_W);
        h = scaled_dim(SRC_H);
        return (32'(y) * SRC_H / h) * SRC_W + 32'(x) * SRC_W / w;
    endfunction

    function automatic int unsigned widen(int unsigned c, int unsigned top);
        return c * 255 / top;
    endfunction

    function automatic logic [7:0] mix_channel(int unsigned f, int unsigned b, int unsigned a);
        return 8'((f * a + b * (255 - a) + 127) / 255);
    endfunction

    function automatic t_result predict_render(t_coord x, t_coord y);
        t_result     r;
        logic [23:0] entry;
        t_word       fg_n;
        t_word       bg_n;
        int unsigned a;
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        r.color = bg_reg;
        r.oor   = 1'b1;
        if (!coord_in_range(x, y)) begin
            return r;
        end
        r.oor = 1'b0;
        entry = sprite_mem[nearest_entry(x, y)];
        a = entry[23:16];
        if (a == 0) begin
            return r;
        end
        fg_n = swap_bytes(entry[15:0]);
        bg_n = swap_bytes(bg_reg);
        r8 = mix_channel(widen(fg_n[15:11], 31), widen(bg_n[15:11], 31), a);
        g8 = mix_channel(widen(fg_n[10:5], 63), widen(bg_n[10:5], 63), a);
        b8 = mix_channel(widen(fg_n[4:0], 31), widen(bg_n[4:0], 31), a);
        r.color = swap_bytes({r8[7:3], g8[7:2], b8[7:3]});
        return r;
    endfunction

    function automatic t_alpha random_alpha();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'd0;
        end else if (pick == 1) begin
            return 8'd255;
        end
        return 8'($urandom);
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** scaled_alpha_sprite_compositor_unit: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result beat, actual color %h out_of_range %b",
                         $time, o_color, o_out_of_range);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                if (o_color !== want.color) begin
                    $display("%0t: color mismatch, expected %h, actual %h",
                             $time, want.color, o_color);
                    mismatch_count++;
                end
                if (o_out_of_range !== want.oor) begin
                    $display("%0t: out_of_range mismatch, expected %b, actual %b",
                             $time, want.oor, o_out_of_range);
                    mismatch_count++;
                end
            end
            stall_left = out_gaps_on ? $urandom_range(0, 7) : 0;
        end
    end

    task automatic send_item(logic cmd, t_load_index li, t_word pw, t_alpha a,
                             t_coord x, t_coord y);
        int unsigned gap;
        gap = in_gaps_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_load_index <= li;
        i_pixel_word <= pw;
        i_alpha      <= a;
        i_out_x      <= x;
        i_out_y      <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            if (32'(li) < STORE_DEPTH) begin
                sprite_mem[li]    = {a, pw};
                sprite_loaded[li] = 1'b1;
            end
        end else begin
            results_due.push_back(predict_render(x, y));
        end
    endtask

    task automatic send_load(t_load_index li, t_word pw, t_alpha a);
        send_item(CMD_LOAD, li, pw, a, 10'($urandom), 10'($urandom));
    endtask

    // A render whose source entry is still empty is preceded by a load of it.
    task automatic send_render(t_coord x, t_coord y);
        int unsigned idx;
        if (coord_in_range(x, y)) begin
            idx = nearest_entry(x, y);
            if (!sprite_loaded[idx]) begin
                send_load(15'(idx), 16'($urandom), random_alpha());
            end
        end
        send_item(CMD_RENDER, 15'($urandom), 16'($urandom), 8'($urandom), x, y);
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, t_word data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_SCALE) begin
            scale_reg = data[8:0];
        end else begin
            bg_reg = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(t_scale scale, t_word bg);
        drain_pipeline();
        write_reg(CFG_SCALE, {7'($urandom), scale});
        write_reg(CFG_BACKGROUND, bg);
    endtask

    task automatic test_reset_defaults();
        send_load(15'd0, 16'hFFFF, 8'd255);
        send_render(10'd0, 10'd0);
        send_load(15'(STORE_DEPTH - 1), 16'h5AA5, 8'd128);
        send_render(10'(SRC_W - 1), 10'(SRC_H - 1));
    endtask

    task automatic test_load_bounds();
        send_load(15'(STORE_DEPTH), 16'h0000, 8'd255);
        send_load(15'h7FFF, 16'hFFFF, 8'd0);
        send_render(10'(SRC_W - 1), 10'(SRC_H - 1));
    endtask

    task automatic test_alpha_extremes();
        send_load(15'd1, 16'h1234, 8'd0);
        send_render(10'd1, 10'd0);
        send_load(15'd2, 16'hFFFF, 8'd1);
        send_render(10'd2, 10'd0);
    endtask

    task automatic test_out_of_range();
        send_render(10'(SRC_W), 10'd0);
        send_render(10'd0, 10'(SRC_H));
        send_render(10'h3FF, 10'h3FF);
    endtask

    task automatic test_scale_extremes();
        set_config(9'd0, 16'hFFFF);
        send_render(10'd0, 10'd0);
        set_config(9'd511, 16'h0000);
        send_render(10'd960, 10'd838);
        send_render(10'd961, 10'd0);
        set_config(9'd1, 16'hFFFF);
        send_render(10'd1, 10'd1);
        send_render(10'd2, 10'd0);
    endtask

    // The sender holds back until every result has come, then goes on.
    task automatic test_drain_pause();
        out_gaps_on = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_render(10'($urandom_range(0, 1)), 10'($urandom_range(0, 1)));
        end
        drain_pipeline();
        send_render(10'd0, 10'd0);
    endtask

    task automatic test_random_traffic();
        int unsigned base_count;
        int unsigned per_phase;
        int unsigned n;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        t_scale      scale;
        t_coord      x;
        t_coord      y;
        base_count = items_sent;
        per_phase = RANDOM_ITEMS / 8;
        for (int unsigned phase = 0; phase < 8; phase++) begin
            case (phase)
                0: scale = 9'd1;
                1: scale = 9'd400;
                2: scale = 9'd511;
                3: scale = 9'd0;
                4: scale = 9'd100;
                default: scale = 9'($urandom_range(1, 400));
            endcase
            set_config(scale, 16'($urandom));
            w = scaled_dim(SRC_W);
            h = scaled_dim(SRC_H);
            n = 0;
            while (items_sent - base_count < (phase + 1) * per_phase) begin
                if (n % 40 == 0) begin
                    in_gaps_on  = $urandom_range(0, 2) != 0;
                    out_gaps_on = $urandom_range(0, 2) != 0;
                end
                pick = $urandom_range(0, 99);
                if (w != 0 && h != 0) begin
                    x = 10'($urandom_range(0, w - 1));
                    y = 10'($urandom_range(0, h - 1));
                end else begin
                    x = 10'($urandom);
                    y = 10'($urandom);
                end
                if (pick < 55) begin
                    send_render(x, y);
                end else if (pick < 67) begin
                    send_render(10'($urandom), 10'($urandom));
                end else if (pick < 85) begin
                    send_load(15'($urandom_range(0, STORE_DEPTH - 1)), 16'($urandom),
                              random_alpha());
                end else if (pick < 96 && coord_in_range(x, y)) begin
                    idx = nearest_entry(x, y);
                    send_load(15'(idx), 16'($urandom), random_alpha());
                    send_render(x, y);
                end else begin
                    send_load(15'($urandom_range(STORE_DEPTH, 32767)), 16'($urandom),
                              random_alpha());
                end
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cmd          = CMD_LOAD;
        i_load_index   = '0;
        i_pixel_word   = '0;
        i_alpha        = '0;
        i_out_x        = '0;
        i_out_y        = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SCALE;
        i_cfg_data     = '0;
        scale_reg      = SCALE_RESET;
        bg_reg         = BG_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        stall_left     = 0;
        items_sent     = 0;
        in_gaps_on     = 1'b1;
        out_gaps_on    = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_load_bounds();
        test_alpha_extremes();
        test_out_of_range();
        test_scale_extremes();
        test_drain_pause();
        test_random_traffic();

        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("** scaled_alpha_sprite_compositor_unit: PASSED **");
        end else begin
            $display("** scaled_alpha_sprite_compositor_unit: FAILED **");
        end
        $finish;
    end

endmodule
